// ===== hw/rtl/bfs_shortest_path_unit_defines.svh =====
// Assertion macros for the shortest path unit.
`ifndef BFS_SHORTEST_PATH_UNIT_DEFINES_SVH
`define BFS_SHORTEST_PATH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BFSSP_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfssp assertion failed");
`define BFSSP_ASSERT(lbl, prop) `BFSSP_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define BFSSP_ASSERT_CLK(lbl, clk, rst_n, prop)
`define BFSSP_ASSERT(lbl, prop)
`endif
`endif

// ===== hw/rtl/bfssp_pkg.sv =====
package bfssp_pkg;

  localparam int unsigned VW = 7;
  localparam int unsigned LW = 6;

  localparam logic [VW-1:0] TARGET_RST = 7'd64;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

  typedef struct packed {
    op_e           op;
    logic [VW-1:0] edge_from;
    logic [VW-1:0] edge_to;
  } item_t;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [LW-1:0] path_length;
    logic          reached;
    logic          is_last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WA,
    ST_EDGE_WB,
    ST_DEQ,
    ST_ROW,
    ST_SCAN,
    ST_WALK_WR,
    ST_WALK_RD,
    ST_EMIT
  } state_e;

endpackage

// ===== hw/rtl/bfssp_ram.sv =====
module bfssp_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bfssp_ffs.sv =====
module bfssp_ffs #(
  parameter int unsigned W = 64
) (
  input  logic [W-1:0]         vec_i,
  output logic                 any_o,
  output logic [$clog2(W)-1:0] idx_o
);

  localparam int unsigned IW = $clog2(W);

  // lowest set bit wins
  always_comb begin
    idx_o = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = IW'(i);
      end
    end
  end

  assign any_o = |vec_i;

endmodule

// ===== hw/rtl/bfs_shortest_path_unit.sv =====
// Channel   Handshake                  Payload                   Direction
// item      start / busy               item_i (item_t)           in
// result    result_valid_o (strobe)    result_o (result_t)       out
// config    cfg_we_i                   cfg_wdata_i (target)      in
//
// Edge beat: ignored if an endpoint is out of range, else two RMW passes on
//   the adjacency RAM, one row per endpoint.
// Run beat: each dequeued vertex passes ST_DEQ and ST_ROW; each newly marked
//   neighbor, and the dry row at the end, takes a scan step; the parent walk
//   alternates stack writes and parent reads; then one result beat per cycle.
// Reset clears adjacency through per-row valid flops; no clearing pass.
// Results are strobed for one cycle and cannot be stalled; busy drops as the
//   last one is registered.
`include "bfs_shortest_path_unit_defines.svh"

module bfs_shortest_path_unit #(
  parameter int unsigned NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bfssp_pkg::item_t    item_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  output logic                result_valid_o,
  output bfssp_pkg::result_t  result_o
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam logic [6:0]  NodesV = 7'(NODES);

  bfssp_pkg::state_e  state_q, state_d;
  logic [6:0]         target_q, target_d;
  logic [NODES-1:0]   row_vld_q, row_vld_d;
  logic               vld_rd_q;
  logic [IW-1:0]      ea_q, ea_d, eb_q, eb_d;
  logic [NODES-1:0]   visited_q, visited_d;
  logic [IW-1:0]      tidx_q, tidx_d;
  logic [CW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [IW-1:0]      cur_q, cur_d;
  logic [IW-1:0]      walk_v_q, walk_v_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [5:0]         len_q, len_d;
  logic [IW-1:0]      ridx_q, ridx_d;
  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q, rd_last_d;
  bfssp_pkg::result_t res_q, res_d;
  logic               res_vld_q, res_vld_d;

  logic               adj_we, adj_re;
  logic [IW-1:0]      adj_waddr, adj_raddr;
  logic [NODES-1:0]   adj_wdata, adj_rdata;
  logic               par_we, par_re;
  logic [IW-1:0]      par_waddr, par_raddr, par_wdata, par_rdata;
  logic               q_we, q_re;
  logic [IW-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;
  logic               stk_we, stk_re;
  logic [IW-1:0]      stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic               accept, edge_ok, tgt_ok, w_any;
  logic [IW-1:0]      a_idx, b_idx, w_idx;
  logic [NODES-1:0]   adj_row, cand;

  bfssp_ram #(.W(NODES), .D(NODES)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .re_i(adj_re), .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  bfssp_ram #(.W(IW), .D(NODES)) u_par (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .re_i(par_re), .raddr_i(par_raddr), .rdata_o(par_rdata)
  );

  bfssp_ram #(.W(IW), .D(NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  bfssp_ram #(.W(IW), .D(NODES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  bfssp_ffs #(.W(NODES)) u_ffs (
    .vec_i(cand), .any_o(w_any), .idx_o(w_idx)
  );

  assign busy    = (state_q != bfssp_pkg::ST_IDLE) || rd_pend_q;
  assign accept  = start && !busy;
  assign edge_ok = (item_i.edge_from != 7'd0) && (item_i.edge_from <= NodesV) &&
                   (item_i.edge_to != 7'd0) && (item_i.edge_to <= NodesV);
  assign tgt_ok  = (target_q != 7'd0) && (target_q <= NodesV);
  assign a_idx   = IW'(item_i.edge_from - 7'd1);
  assign b_idx   = IW'(item_i.edge_to - 7'd1);
  assign adj_row = vld_rd_q ? adj_rdata : '0;
  assign cand    = adj_row & ~visited_q;

  always_comb begin
    state_d   = state_q;
    target_d  = cfg_we_i ? cfg_wdata_i : target_q;
    row_vld_d = row_vld_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    visited_d = visited_q;
    tidx_d    = tidx_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cur_d     = cur_q;
    walk_v_d  = walk_v_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    ridx_d    = ridx_q;
    rd_pend_d = 1'b0;
    rd_last_d = rd_last_q;
    res_d     = res_q;
    res_vld_d = 1'b0;

    adj_we    = 1'b0;
    adj_waddr = ea_q;
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = a_idx;
    par_we    = 1'b0;
    par_waddr = w_idx;
    par_wdata = cur_q;
    par_re    = 1'b0;
    par_raddr = walk_v_q;
    q_we      = 1'b0;
    q_waddr   = tail_q[IW-1:0];
    q_wdata   = w_idx;
    q_re      = 1'b0;
    q_raddr   = head_q[IW-1:0];
    stk_we    = 1'b0;
    stk_waddr = cnt_q[IW-1:0];
    stk_wdata = walk_v_q;
    stk_re    = 1'b0;
    stk_raddr = ridx_q;

    unique case (state_q)
      bfssp_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_i.op == bfssp_pkg::OP_EDGE) begin
            if (edge_ok) begin
              ea_d      = a_idx;
              eb_d      = b_idx;
              adj_re    = 1'b1;
              adj_raddr = a_idx;
              state_d   = bfssp_pkg::ST_EDGE_WA;
            end
          end else if (!tgt_ok) begin
            res_d     = '{vertex: target_q, path_length: 6'd0, reached: 1'b0,
                          is_last: 1'b1};
            res_vld_d = 1'b1;
          end else begin
            tidx_d    = IW'(target_q - 7'd1);
            visited_d = NODES'(1);
            if (target_q == 7'd1) begin
              walk_v_d = '0;
              cnt_d    = '0;
              state_d  = bfssp_pkg::ST_WALK_WR;
            end else begin
              q_we    = 1'b1;
              q_waddr = '0;
              q_wdata = '0;
              head_d  = '0;
              tail_d  = CW'(1);
              state_d = bfssp_pkg::ST_DEQ;
            end
          end
        end
      end
      bfssp_pkg::ST_EDGE_WA: begin
        adj_we    = 1'b1;
        adj_waddr = ea_q;
        adj_wdata = adj_row | (NODES'(1) << eb_q);
        row_vld_d[ea_q] = 1'b1;
        adj_re    = 1'b1;
        adj_raddr = eb_q;
        state_d   = bfssp_pkg::ST_EDGE_WB;
      end
      bfssp_pkg::ST_EDGE_WB: begin
        adj_we    = 1'b1;
        adj_waddr = eb_q;
        adj_wdata = adj_row | (NODES'(1) << ea_q);
        row_vld_d[eb_q] = 1'b1;
        state_d   = bfssp_pkg::ST_IDLE;
      end
      bfssp_pkg::ST_DEQ: begin
        if (head_q < tail_q) begin
          q_re    = 1'b1;
          head_d  = head_q + CW'(1);
          state_d = bfssp_pkg::ST_ROW;
        end else begin
          res_d     = '{vertex: target_q, path_length: 6'd0, reached: 1'b0,
                        is_last: 1'b1};
          res_vld_d = 1'b1;
          state_d   = bfssp_pkg::ST_IDLE;
        end
      end
      bfssp_pkg::ST_ROW: begin
        cur_d     = q_rdata;
        adj_re    = 1'b1;
        adj_raddr = q_rdata;
        state_d   = bfssp_pkg::ST_SCAN;
      end
      bfssp_pkg::ST_SCAN: begin
        if (!w_any) begin
          state_d = bfssp_pkg::ST_DEQ;
        end else begin
          visited_d = visited_q | (NODES'(1) << w_idx);
          par_we    = 1'b1;
          if (w_idx == tidx_q) begin
            walk_v_d = w_idx;
            cnt_d    = '0;
            state_d  = bfssp_pkg::ST_WALK_WR;
          end else if (tail_q < CW'(NODES)) begin
            q_we   = 1'b1;
            tail_d = tail_q + CW'(1);
          end
        end
      end
      bfssp_pkg::ST_WALK_WR: begin
        stk_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
        if (walk_v_q == '0) begin
          len_d   = 6'(cnt_q);
          ridx_d  = cnt_q[IW-1:0];
          state_d = bfssp_pkg::ST_EMIT;
        end else begin
          par_re  = 1'b1;
          state_d = bfssp_pkg::ST_WALK_RD;
        end
      end
      bfssp_pkg::ST_WALK_RD: begin
        walk_v_d = par_rdata;
        state_d  = bfssp_pkg::ST_WALK_WR;
      end
      bfssp_pkg::ST_EMIT: begin
        stk_re    = 1'b1;
        rd_pend_d = 1'b1;
        rd_last_d = (ridx_q == '0);
        if (ridx_q == '0) begin
          state_d = bfssp_pkg::ST_IDLE;
        end else begin
          ridx_d = ridx_q - IW'(1);
        end
      end
      default: begin
        state_d = bfssp_pkg::ST_IDLE;
      end
    endcase

    if (rd_pend_q) begin
      res_d     = '{vertex: 7'(stk_rdata) + 7'd1, path_length: len_q, reached: 1'b1,
                    is_last: rd_last_q};
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bfssp_pkg::ST_IDLE;
      target_q  <= bfssp_pkg::TARGET_RST;
      row_vld_q <= '0;
      rd_pend_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      target_q  <= target_d;
      row_vld_q <= row_vld_d;
      rd_pend_q <= rd_pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_re) begin
      vld_rd_q <= row_vld_q[adj_raddr];
    end
    ea_q      <= ea_d;
    eb_q      <= eb_d;
    visited_q <= visited_d;
    tidx_q    <= tidx_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
    cur_q     <= cur_d;
    walk_v_q  <= walk_v_d;
    cnt_q     <= cnt_d;
    len_q     <= len_d;
    ridx_q    <= ridx_d;
    rd_last_q <= rd_last_d;
    res_q     <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  `BFSSP_ASSERT(a_pend_res, rd_pend_q |=> (res_vld_q && res_q.reached))
  `BFSSP_ASSERT(a_bad_tgt,
    (accept && item_i.op == bfssp_pkg::OP_RUN && !tgt_ok) |=>
    (res_vld_q && !res_q.reached && res_q.is_last))
  `BFSSP_ASSERT(a_tail_bound,
    (state_q == bfssp_pkg::ST_SCAN) |-> (tail_q <= CW'(NODES) && visited_q[0]))
  `BFSSP_ASSERT(a_emit_idx, (state_q == bfssp_pkg::ST_EMIT) |-> (CW'(ridx_q) < cnt_q))

endmodule
